// ----- hdl/assert_macros.svh -----
// ------------------------------------------------------------------------------------------------
// Assertion macros
// Short forms for the concurrent checks used across the fire shader project.
// ------------------------------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, held off while rst is high
`define FPS_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("fire shader check failed");

// next-cycle implication, held off while rst is high
`define FPS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("fire shader check failed");

`endif

// ----- hdl/fps_pkg.sv -----
// ------------------------------------------------------------------------------------------------
// Fire pixel shader package
// Geometry constants, field widths, register codes and reset values.
// ------------------------------------------------------------------------------------------------
package fps_pkg;

   // face geometry
   localparam int FACE_SIZE       = 8;
   localparam int SIDE_FACE_COUNT = 4;
   localparam int FACE_AREA       = FACE_SIZE * FACE_SIZE;

   // field widths
   localparam int FACE_BITS      = 3;
   localparam int FACE_NUM_BITS  = 2;
   localparam int LOCAL_BITS     = 2 * FACE_BITS;
   localparam int PIX_BITS       = 8;
   localparam int LED_INDEX_BITS = 8;
   localparam int CSR_DATA_BITS  = 8;
   localparam int CSR_INDEX_BITS = 3;

   typedef logic [FACE_BITS-1:0]      coord_type;
   typedef logic [FACE_NUM_BITS-1:0]  face_type;
   typedef logic [PIX_BITS-1:0]       pix_type;
   typedef logic [LED_INDEX_BITS-1:0] led_index_type;

   // register indexes on the csr port
   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_COOLING       = 3'd0,
      CSR_HUE_RANGE     = 3'd1,
      CSR_BASE_HUE      = 3'd2,
      CSR_ROTATION      = 3'd3,
      CSR_ORIGIN_CORNER = 3'd4,
      CSR_SERPENTINE    = 3'd5,
      CSR_CHAIN_AXIS    = 3'd6
   } csr_index_type;

   // quarter-turn codes
   localparam logic [1:0] ROT_0   = 2'd0;
   localparam logic [1:0] ROT_90  = 2'd1;
   localparam logic [1:0] ROT_180 = 2'd2;
   localparam logic [1:0] ROT_270 = 2'd3;

   // register reset values
   localparam pix_type    COOLING_RESET       = 8'd64;
   localparam pix_type    HUE_RANGE_RESET     = 8'd64;
   localparam pix_type    BASE_HUE_RESET      = 8'd0;
   localparam logic [1:0] ROTATION_RESET      = ROT_0;
   localparam logic [1:0] ORIGIN_CORNER_RESET = 2'd0;
   localparam logic       SERPENTINE_RESET    = 1'b0;
   localparam logic       CHAIN_AXIS_RESET    = 1'b0;

endpackage

// ----- hdl/fps_if.sv -----
// ------------------------------------------------------------------------------------------------
// Fire pixel shader channels
// Valid/ready request and result channels carrying the pixel payloads.
// ------------------------------------------------------------------------------------------------

// pixel request channel
interface fps_req_if;
   import fps_pkg::*;

   logic      valid;
   logic      ready;
   face_type  face_number;
   coord_type column;
   coord_type heat_row;
   pix_type   heat_here;
   pix_type   heat_below;
   pix_type   phase;
   pix_type   value_mask;
   pix_type   tint_mask;

   modport source (
      output valid, face_number, column, heat_row, heat_here, heat_below,
             phase, value_mask, tint_mask,
      input  ready
   );
   modport sink (
      input  valid, face_number, column, heat_row, heat_here, heat_below,
             phase, value_mask, tint_mask,
      output ready
   );
   modport monitor (
      input valid, ready, face_number, column, heat_row, heat_here, heat_below,
            phase, value_mask, tint_mask
   );
endinterface

// shaded pixel result channel
interface fps_rsp_if;
   import fps_pkg::*;

   logic          valid;
   logic          ready;
   led_index_type led_index;
   pix_type       red;
   pix_type       green;
   pix_type       blue;

   modport source (
      output valid, led_index, red, green, blue,
      input  ready
   );
   modport sink (
      input  valid, led_index, red, green, blue,
      output ready
   );
   modport monitor (
      input valid, ready, led_index, red, green, blue
   );
endinterface

// ----- hdl/fire_pixel_shader.sv -----
// ------------------------------------------------------------------------------------------------
// Fire pixel shader: heat blend, cooling, hue offset, HSV to RGB and LED index mapping
// Pipeline: four register stages between request acceptance and result valid.
// Throughput: one request per cycle; each stage holds under backpressure and fills bubbles.
// Reset: synchronous, clears all valid bits and loads the register defaults.
// ------------------------------------------------------------------------------------------------
module fire_pixel_shader (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_write_en,
   input  logic [fps_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [fps_pkg::CSR_DATA_BITS-1:0]  csr_write_data,
   fps_req_if.sink                          req_ch,
   fps_rsp_if.source                        rsp_ch
);
   import fps_pkg::*;

   // hue sectors of the HSV wheel
   typedef enum logic [2:0] {
      SEC_RED     = 3'd0,
      SEC_YELLOW  = 3'd1,
      SEC_GREEN   = 3'd2,
      SEC_CYAN    = 3'd3,
      SEC_BLUE    = 3'd4,
      SEC_MAGENTA = 3'd5
   } sector_type;

   localparam coord_type FACE_LAST = FACE_BITS'(FACE_SIZE - 1);

   // floor(m * 255 / 2^24), clamped to a byte
   function automatic pix_type chan_scale(input logic [24:0] m);
      logic [32:0] t;
      t = {m, 8'b0} - {8'b0, m};
      return t[32] ? 8'hFF : t[31:24];
   endfunction

   // ---------------------------------------------------------------------------------------------
   // configuration registers
   // ---------------------------------------------------------------------------------------------
   pix_type    cooling_ff, hue_range_ff, base_hue_ff;
   logic [1:0] rotation_ff, origin_corner_ff;
   logic       serpentine_ff, chain_axis_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cooling_ff       <= COOLING_RESET;
         hue_range_ff     <= HUE_RANGE_RESET;
         base_hue_ff      <= BASE_HUE_RESET;
         rotation_ff      <= ROTATION_RESET;
         origin_corner_ff <= ORIGIN_CORNER_RESET;
         serpentine_ff    <= SERPENTINE_RESET;
         chain_axis_ff    <= CHAIN_AXIS_RESET;
      end else if (csr_write_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_COOLING:       cooling_ff       <= csr_write_data;
            CSR_HUE_RANGE:     hue_range_ff     <= csr_write_data;
            CSR_BASE_HUE:      base_hue_ff      <= csr_write_data;
            CSR_ROTATION:      rotation_ff      <= csr_write_data[1:0];
            CSR_ORIGIN_CORNER: origin_corner_ff <= csr_write_data[1:0];
            CSR_SERPENTINE:    serpentine_ff    <= csr_write_data[0];
            CSR_CHAIN_AXIS:    chain_axis_ff    <= csr_write_data[0];
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------------------------------------
   // stage flow control: a stage moves on when it is empty or its successor moves
   // ---------------------------------------------------------------------------------------------
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, out_valid_ff;
   logic s1_adv, s2_adv, s3_adv, out_adv;

   assign out_adv      = !out_valid_ff || rsp_ch.ready;
   assign s3_adv       = !s3_valid_ff  || out_adv;
   assign s2_adv       = !s2_valid_ff  || s3_adv;
   assign s1_adv       = !s1_valid_ff  || s2_adv;
   assign req_ch.ready = s1_adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (s1_adv)  s1_valid_ff  <= req_ch.valid;
         if (s2_adv)  s2_valid_ff  <= s1_valid_ff;
         if (s3_adv)  s3_valid_ff  <= s2_valid_ff;
         if (out_adv) out_valid_ff <= s3_valid_ff;
      end
   end

   // ---------------------------------------------------------------------------------------------
   // stage 1: blend and mask products, LED index mapping
   // ---------------------------------------------------------------------------------------------
   logic [16:0]   s1_blend_a_in, s1_blend_a_ff;
   logic [15:0]   s1_blend_b_in, s1_blend_b_ff;
   logic [15:0]   s1_cool_in,    s1_cool_ff;
   logic [15:0]   s1_hue_off_in, s1_hue_off_ff;
   led_index_type s1_index_in,   s1_index_ff;

   logic [8:0]           ph_inv;
   face_type             face_mod;
   coord_type            col_mod, row_mod;
   coord_type            px, py, px_rot, py_rot;
   logic [LOCAL_BITS-1:0] local_offset;

   assign ph_inv        = 9'd256 - {1'b0, req_ch.phase};
   assign s1_blend_a_in = ph_inv * req_ch.heat_here;
   assign s1_blend_b_in = req_ch.phase * req_ch.heat_below;
   assign s1_cool_in    = req_ch.value_mask * cooling_ff;
   assign s1_hue_off_in = req_ch.tint_mask * hue_range_ff;

   // face coordinates to chain offset: rotate, mirror, then walk the chain
   always_comb begin
      face_mod = FACE_NUM_BITS'(32'(req_ch.face_number) % SIDE_FACE_COUNT);
      col_mod  = FACE_BITS'(32'(req_ch.column) % FACE_SIZE);
      row_mod  = FACE_BITS'(32'(req_ch.heat_row) % FACE_SIZE);
      px       = col_mod;
      py       = FACE_LAST - row_mod;

      case (rotation_ff)
         ROT_90: begin
            px_rot = FACE_LAST - py;
            py_rot = px;
         end
         ROT_180: begin
            px_rot = FACE_LAST - px;
            py_rot = FACE_LAST - py;
         end
         ROT_270: begin
            px_rot = py;
            py_rot = FACE_LAST - px;
         end
         default: begin
            px_rot = px;
            py_rot = py;
         end
      endcase

      if (origin_corner_ff[0]) px_rot = FACE_LAST - px_rot;
      if (origin_corner_ff[1]) py_rot = FACE_LAST - py_rot;

      if (chain_axis_ff) begin
         if (serpentine_ff && px_rot[0]) py_rot = FACE_LAST - py_rot;
         local_offset = LOCAL_BITS'(32'(px_rot) * FACE_SIZE + 32'(py_rot));
      end else begin
         if (serpentine_ff && py_rot[0]) px_rot = FACE_LAST - px_rot;
         local_offset = LOCAL_BITS'(32'(py_rot) * FACE_SIZE + 32'(px_rot));
      end

      s1_index_in = LED_INDEX_BITS'(32'(face_mod) * FACE_AREA + 32'(local_offset));
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         s1_blend_a_ff <= s1_blend_a_in;
         s1_blend_b_ff <= s1_blend_b_in;
         s1_cool_ff    <= s1_cool_in;
         s1_hue_off_ff <= s1_hue_off_in;
         s1_index_ff   <= s1_index_in;
      end
   end

   // ---------------------------------------------------------------------------------------------
   // stage 2: brightness with cooling and clamp; hue, sector and interpolation factors
   // ---------------------------------------------------------------------------------------------
   pix_type       s2_val_in, s2_val_ff;
   sector_type    s2_sector_in, s2_sector_ff;
   logic [16:0]   s2_fq_in, s2_fq_ff;
   logic [16:0]   s2_ft_in, s2_ft_ff;
   led_index_type s2_index_ff;

   logic [16:0] blend;
   logic [18:0] diff;
   pix_type     hue;
   logic [10:0] hue6;
   logic [15:0] frac255;

   always_comb begin
      // blend minus four times the cooling product; the 1/256 scale is the top byte
      blend = s1_blend_a_ff + 17'(s1_blend_b_ff);
      diff  = 19'(blend) - 19'({s1_cool_ff, 2'b00});
      if (diff[18])
         s2_val_in = '0;
      else if (|diff[17:16])
         s2_val_in = 8'hFF;
      else
         s2_val_in = diff[15:8];

      // hue wraps modulo 256, six sectors over the turn
      hue          = base_hue_ff + s1_hue_off_ff[13:6];
      hue6         = {1'b0, hue, 2'b00} + {2'b00, hue, 1'b0};
      s2_sector_in = sector_type'(hue6[10:8]);
      frac255      = {hue6[7:0], 8'b0} - {8'b0, hue6[7:0]};
      s2_fq_in     = 17'h10000 - 17'(frac255);
      s2_ft_in     = 17'(frac255) + 17'd256;
   end

   always_ff @(posedge clock) begin
      if (s2_adv) begin
         s2_val_ff    <= s2_val_in;
         s2_sector_ff <= s2_sector_in;
         s2_fq_ff     <= s2_fq_in;
         s2_ft_ff     <= s2_ft_in;
         s2_index_ff  <= s1_index_ff;
      end
   end

   // ---------------------------------------------------------------------------------------------
   // stage 3: brightness times the falling and rising factors
   // ---------------------------------------------------------------------------------------------
   pix_type       s3_cv_in, s3_cv_ff;
   logic [24:0]   s3_mq_in, s3_mq_ff;
   logic [24:0]   s3_mt_in, s3_mt_ff;
   sector_type    s3_sector_ff;
   led_index_type s3_index_ff;
   logic [15:0]   val255;

   assign val255   = {s2_val_ff, 8'b0} - {8'b0, s2_val_ff};
   assign s3_cv_in = val255[15:8];
   assign s3_mq_in = s2_val_ff * s2_fq_ff;
   assign s3_mt_in = s2_val_ff * s2_ft_ff;

   always_ff @(posedge clock) begin
      if (s3_adv) begin
         s3_cv_ff     <= s3_cv_in;
         s3_mq_ff     <= s3_mq_in;
         s3_mt_ff     <= s3_mt_in;
         s3_sector_ff <= s2_sector_ff;
         s3_index_ff  <= s2_index_ff;
      end
   end

   // ---------------------------------------------------------------------------------------------
   // stage 4: scale to drive levels and route by sector into the output register
   // ---------------------------------------------------------------------------------------------
   pix_type       cq, ct;
   pix_type       red_in, green_in, blue_in;
   pix_type       red_ff, green_ff, blue_ff;
   led_index_type led_index_ff;

   // the desaturated channel always rounds down to zero at s = 255/256
   always_comb begin
      cq = chan_scale(s3_mq_ff);
      ct = chan_scale(s3_mt_ff);
      case (s3_sector_ff)
         SEC_RED: begin
            red_in = s3_cv_ff; green_in = ct;       blue_in = '0;
         end
         SEC_YELLOW: begin
            red_in = cq;       green_in = s3_cv_ff; blue_in = '0;
         end
         SEC_GREEN: begin
            red_in = '0;       green_in = s3_cv_ff; blue_in = ct;
         end
         SEC_CYAN: begin
            red_in = '0;       green_in = cq;       blue_in = s3_cv_ff;
         end
         SEC_BLUE: begin
            red_in = ct;       green_in = '0;       blue_in = s3_cv_ff;
         end
         default: begin
            red_in = s3_cv_ff; green_in = '0;       blue_in = cq;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (out_adv) begin
         red_ff       <= red_in;
         green_ff     <= green_in;
         blue_ff      <= blue_in;
         led_index_ff <= s3_index_ff;
      end
   end

   assign rsp_ch.valid     = out_valid_ff;
   assign rsp_ch.led_index = led_index_ff;
   assign rsp_ch.red       = red_ff;
   assign rsp_ch.green     = green_ff;
   assign rsp_ch.blue      = blue_ff;

endmodule

// ----- hdl/fps_checker.sv -----
// ------------------------------------------------------------------------------------------------
// Fire pixel shader checker
// Port-level checks on reset, result hold, pipeline latency and colour saturation.
// ------------------------------------------------------------------------------------------------
`include "assert_macros.svh"

module fps_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_ready,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input fps_pkg::led_index_type rsp_led_index,
   input fps_pkg::pix_type       rsp_red,
   input fps_pkg::pix_type       rsp_green,
   input fps_pkg::pix_type       rsp_blue
);
   logic        req_fire;
   logic        rsp_stall;
   logic        rsp_one_dark;
   logic [31:0] rsp_payload;

   assign req_fire     = req_valid && req_ready;
   assign rsp_stall    = rsp_valid && !rsp_ready;
   assign rsp_one_dark = (rsp_red == 8'd0) || (rsp_green == 8'd0) || (rsp_blue == 8'd0);
   assign rsp_payload  = {rsp_led_index, rsp_red, rsp_green, rsp_blue};

   // nothing comes out right after reset
   `FPS_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_valid)

   // a stalled result holds
   `FPS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_valid && $stable(rsp_payload))

   // with the sink always ready an accepted request passes the stage registers and shows up as a valid result
   `FPS_ASSERT_NEXT(a_latency, clock, reset, req_fire ##1 rsp_ready [*3], rsp_valid)

   // near-full saturation leaves one channel dark in every sector
   `FPS_ASSERT_IMPL(a_one_dark, clock, reset, rsp_valid, rsp_one_dark)

endmodule

bind fire_pixel_shader fps_checker u_fps_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_ch.valid),
   .req_ready     (req_ch.ready),
   .rsp_valid     (rsp_ch.valid),
   .rsp_ready     (rsp_ch.ready),
   .rsp_led_index (rsp_ch.led_index),
   .rsp_red       (rsp_ch.red),
   .rsp_green     (rsp_ch.green),
   .rsp_blue      (rsp_ch.blue)
);

// ----- tb/tb_fire_pixel_shader.sv -----
`timescale 1ns / 100ps
// ------------------------------------------------------------------------------------------------
// Fire pixel shader testbench
// Sends pixel requests under random idling and backpressure across a sweep of register settings.
// Every result is checked against an in-bench model of the blend, cooling, hue, HSV and LED index
// maths, or against values typed into the table. The run starts with a short table of edge cases
// and then continues with random pixels.
// ------------------------------------------------------------------------------------------------
module tb_fire_pixel_shader;
   import fps_pkg::*;

   localparam int CLOCK_PERIOD     = 8;
   localparam int RESET_CYCLES     = 6;
   localparam int PHASE_COUNT      = 16;
   localparam int ITEMS_PER_PHASE  = 112;
   localparam int LONG_HOLD_CYCLES = 60;
   localparam int DRAIN_CYCLES     = 12;
   localparam int MAX_REPORTS      = 60;
   localparam int TIMEOUT_NS       = 2_000_000;
   localparam int DIRECTED_COUNT   = 15;

   localparam coord_type                 FACE_LAST        = coord_type'(FACE_SIZE - 1);
   localparam logic [CSR_INDEX_BITS-1:0] CSR_INDEX_UNUSED = 3'd7;

   // six hue sectors of the HSV wheel
   typedef enum logic [2:0] {
      SECTOR_RED     = 3'd0,
      SECTOR_YELLOW  = 3'd1,
      SECTOR_GREEN   = 3'd2,
      SECTOR_CYAN    = 3'd3,
      SECTOR_BLUE    = 3'd4,
      SECTOR_MAGENTA = 3'd5
   } hue_sector_type;

   typedef struct packed {
      face_type  face_number;
      coord_type column;
      coord_type heat_row;
      pix_type   heat_here;
      pix_type   heat_below;
      pix_type   phase;
      pix_type   value_mask;
      pix_type   tint_mask;
   } pixel_request_type;

   typedef struct packed {
      led_index_type led_index;
      pix_type       red;
      pix_type       green;
      pix_type       blue;
   } shaded_pixel_type;

   typedef struct packed {
      pixel_request_type px;
      logic              typed;
      shaded_pixel_type  want;
   } directed_row_type;

   logic clock = 1'b0;
   logic reset;
   logic                      csr_write_en;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CSR_DATA_BITS-1:0]  csr_write_data;

   fps_req_if pixel_req ();
   fps_rsp_if pixel_rsp ();

   // bench copy of the lamp registers
   pix_type    lamp_cooling;
   pix_type    lamp_hue_range;
   pix_type    lamp_base_hue;
   logic [1:0] lamp_rotation;
   logic [1:0] lamp_origin;
   logic       lamp_serpentine;
   logic       lamp_chain_axis;

   shaded_pixel_type pending_pixels [$];
   int req_idle_pct;
   int rsp_idle_pct;
   bit hold_off_request;
   int mismatch_count;
   int requests_sent;
   int results_seen;

   // edge cases: reset settings throughout
   //   face  col   row   here     below    phase    vmask    tmask   typed  led/r/g/b
   directed_row_type directed_rows [DIRECTED_COUNT] = '{
      {2'd0, 3'd0, 3'd0, 8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   1'b1,
       8'd56,  8'd0,   8'd0,   8'd0},
      {2'd3, 3'd7, 3'd7, 8'd255, 8'd255, 8'd0,   8'd0,   8'd0,   1'b1,
       8'd199, 8'd254, 8'd0,   8'd0},
      {2'd1, 3'd0, 3'd0, 8'd0,   8'd255, 8'd255, 8'd0,   8'd0,   1'b1,
       8'd120, 8'd253, 8'd0,   8'd0},
      {2'd2, 3'd3, 3'd4, 8'd255, 8'd255, 8'd0,   8'd255, 8'd255, 1'b1,
       8'd155, 8'd0,   8'd0,   8'd0},
      {2'd0, 3'd5, 3'd2, 8'd255, 8'd255, 8'd0,   8'd0,   8'd128, 1'b1,
       8'd45,  8'd0,   8'd254, 8'd254},
      {2'd0, 3'd2, 3'd1, 8'd200, 8'd100, 8'd128, 8'd10,  8'd43,  1'b0, 32'd0},
      {2'd1, 3'd4, 3'd6, 8'd50,  8'd250, 8'd64,  8'd0,   8'd86,  1'b0, 32'd0},
      {2'd2, 3'd6, 3'd3, 8'd255, 8'd0,   8'd255, 8'd0,   8'd171, 1'b0, 32'd0},
      {2'd3, 3'd1, 3'd5, 8'd128, 8'd128, 8'd0,   8'd1,   8'd214, 1'b0, 32'd0},
      {2'd0, 3'd7, 3'd0, 8'd255, 8'd255, 8'd0,   8'd0,   8'd255, 1'b0, 32'd0},
      {2'd1, 3'd3, 3'd3, 8'd255, 8'd255, 8'd1,   8'd0,   8'd42,  1'b0, 32'd0},
      {2'd2, 3'd0, 3'd7, 8'd17,  8'd240, 8'd200, 8'd255, 8'd127, 1'b0, 32'd0},
      {2'd3, 3'd5, 3'd2, 8'd255, 8'd255, 8'd0,   8'd2,   8'd20,  1'b0, 32'd0},
      {2'd1, 3'd2, 3'd5, 8'hAA,  8'h55,  8'hA5,  8'h5A,  8'hAA,  1'b0, 32'd0},
      {2'd2, 3'd5, 3'd2, 8'h55,  8'hAA,  8'h5A,  8'hA5,  8'h55,  1'b0, 32'd0}
   };

   fire_pixel_shader DUT (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data),
      .req_ch         (pixel_req),
      .rsp_ch         (pixel_rsp)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // floor(level/256 * factor/65536 * 255), clamped
   function automatic pix_type channel_level(pix_type level, logic [16:0] factor);
      logic [63:0] scaled;
      scaled = (64'(level) * 64'(factor) * 64'd255) >> 24;
      return (scaled > 64'd255) ? 8'd255 : scaled[7:0];
   endfunction

   // expected LED index and colour for one pixel under the current lamp settings
   function automatic shaded_pixel_type shade_pixel(pixel_request_type px);
      logic [31:0]       blend;
      logic [31:0]       cool;
      logic [31:0]       level_wide;
      pix_type           level;
      logic [15:0]       hue_offset;
      pix_type           hue;
      logic [10:0]       hue6;
      pix_type           frac;
      pix_type           lv_v;
      pix_type           lv_p;
      pix_type           lv_q;
      pix_type           lv_t;
      coord_type         x;
      coord_type         y;
      coord_type         tmp;
      int                local_offset;
      shaded_pixel_type  res;

      // brightness: blend towards the cell below, minus cooling, clamped
      blend = ((32'd256 - px.phase) * px.heat_here + px.phase * px.heat_below) * 32'd64;
      cool  = px.value_mask * lamp_cooling * 32'd256;
      level = '0;
      if (blend > cool) begin
         level_wide = (blend - cool) >> 14;
         level      = (level_wide > 32'd255) ? 8'd255 : level_wide[7:0];
      end

      // hue wraps modulo one turn
      hue_offset = (16'(px.tint_mask) * 16'(lamp_hue_range)) >> 6;
      hue        = lamp_base_hue + hue_offset[7:0];

      hue6 = 11'(hue) * 11'd6;
      frac = hue6[7:0];
      lv_v = channel_level(level, 17'd65536);
      lv_p = channel_level(level, 17'd256);
      lv_q = channel_level(level, 17'd65536 - 17'd255 * frac);
      lv_t = channel_level(level, 17'd65536 - 17'd255 * (17'd256 - frac));
      case (hue_sector_type'(hue6[10:8]))
         SECTOR_RED: begin
            res.red = lv_v; res.green = lv_t; res.blue = lv_p;
         end
         SECTOR_YELLOW: begin
            res.red = lv_q; res.green = lv_v; res.blue = lv_p;
         end
         SECTOR_GREEN: begin
            res.red = lv_p; res.green = lv_v; res.blue = lv_t;
         end
         SECTOR_CYAN: begin
            res.red = lv_p; res.green = lv_q; res.blue = lv_v;
         end
         SECTOR_BLUE: begin
            res.red = lv_t; res.green = lv_p; res.blue = lv_v;
         end
         default: begin
            res.red = lv_v; res.green = lv_p; res.blue = lv_q;
         end
      endcase

      // face geometry: heat rows count from the bottom, display rows from the top
      x = px.column;
      y = FACE_LAST - px.heat_row;
      case (lamp_rotation)
         ROT_90: begin
            tmp = x; x = FACE_LAST - y; y = tmp;
         end
         ROT_180: begin
            x = FACE_LAST - x; y = FACE_LAST - y;
         end
         ROT_270: begin
            tmp = x; x = y; y = FACE_LAST - tmp;
         end
         default: ;
      endcase
      if (lamp_origin[0]) x = FACE_LAST - x;
      if (lamp_origin[1]) y = FACE_LAST - y;
      if (lamp_chain_axis) begin
         if (lamp_serpentine && x[0]) y = FACE_LAST - y;
         local_offset = x * FACE_SIZE + y;
      end else begin
         if (lamp_serpentine && y[0]) x = FACE_LAST - x;
         local_offset = y * FACE_SIZE + x;
      end
      res.led_index = led_index_type'((px.face_number % SIDE_FACE_COUNT) * FACE_AREA
                                      + local_offset);
      return res;
   endfunction

   task automatic report_mismatch(string what);
      if (mismatch_count < MAX_REPORTS) $display("%0d ns  mismatch: %s", $time, what);
      mismatch_count++;
   endtask

   task automatic check_field(string name, pix_type got, pix_type want);
      if (got !== want)
         report_mismatch($sformatf("%s got %0d, expected %0d", name, got, want));
   endtask

   // one register write per cycle; the caller lowers the enable after the last
   task automatic write_register(logic [CSR_INDEX_BITS-1:0] idx, pix_type data);
      @(negedge clock);
      csr_write_en   <= 1'b1;
      csr_index      <= idx;
      csr_write_data <= data;
      case (idx)
         CSR_COOLING:       lamp_cooling    = data;
         CSR_HUE_RANGE:     lamp_hue_range  = data;
         CSR_BASE_HUE:      lamp_base_hue   = data;
         CSR_ROTATION:      lamp_rotation   = data[1:0];
         CSR_ORIGIN_CORNER: lamp_origin     = data[1:0];
         CSR_SERPENTINE:    lamp_serpentine = data[0];
         CSR_CHAIN_AXIS:    lamp_chain_axis = data[0];
         default: ;
      endcase
   endtask

   // offer one request, idling first at the current rate; returns at a falling edge
   task automatic send_pixel(pixel_request_type px, shaded_pixel_type want);
      while ($urandom_range(0, 99) < req_idle_pct) begin
         pixel_req.valid <= 1'b0;
         @(negedge clock);
      end
      pixel_req.valid       <= 1'b1;
      pixel_req.face_number <= px.face_number;
      pixel_req.column      <= px.column;
      pixel_req.heat_row    <= px.heat_row;
      pixel_req.heat_here   <= px.heat_here;
      pixel_req.heat_below  <= px.heat_below;
      pixel_req.phase       <= px.phase;
      pixel_req.value_mask  <= px.value_mask;
      pixel_req.tint_mask   <= px.tint_mask;
      do @(posedge clock); while (!pixel_req.ready);
      pending_pixels.push_back(want);
      requests_sent++;
      @(negedge clock);
   endtask

   // always waits for a falling edge before it checks, so valid is never dropped and raised in one step
   task automatic drain_results();
      do @(negedge clock); while (pending_pixels.size() != 0);
   endtask

   // result receiver: random stalls, plus one long hold-off on demand
   initial begin : result_receiver
      int hold_left;
      hold_left       = 0;
      pixel_rsp.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_request) begin
            hold_off_request = 1'b0;
            hold_left        = LONG_HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            pixel_rsp.ready <= 1'b0;
            hold_left--;
         end else begin
            pixel_rsp.ready <= ($urandom_range(0, 99) >= rsp_idle_pct);
         end
      end
   end

   // compare each accepted result with the oldest expectation
   always @(posedge clock) begin : result_check
      shaded_pixel_type want;
      if (!reset && pixel_rsp.valid && pixel_rsp.ready) begin
         results_seen++;
         if (pending_pixels.size() == 0) begin
            report_mismatch($sformatf("unexpected result, led_index %0d", pixel_rsp.led_index));
         end else begin
            want = pending_pixels.pop_front();
            check_field("led_index", pixel_rsp.led_index, want.led_index);
            check_field("red", pixel_rsp.red, want.red);
            check_field("green", pixel_rsp.green, want.green);
            check_field("blue", pixel_rsp.blue, want.blue);
         end
      end
   end

   initial begin : watchdog
      #(TIMEOUT_NS);
      $display("Test completed with failures");
      $finish;
   end

   initial begin : stimulus
      pixel_request_type px;
      shaded_pixel_type  want;
      pix_type           cool_set;
      pix_type           range_set;
      pix_type           hue_set;
      pix_type           noise;
      logic [3:0]        geo;

      pixel_req.valid       = 1'b0;
      pixel_req.face_number = '0;
      pixel_req.column      = '0;
      pixel_req.heat_row    = '0;
      pixel_req.heat_here   = '0;
      pixel_req.heat_below  = '0;
      pixel_req.phase       = '0;
      pixel_req.value_mask  = '0;
      pixel_req.tint_mask   = '0;
      csr_write_en          = 1'b0;
      csr_index             = '0;
      csr_write_data        = '0;
      hold_off_request      = 1'b0;
      mismatch_count        = 0;
      requests_sent         = 0;
      results_seen          = 0;
      req_idle_pct          = 19;
      rsp_idle_pct          = 58;
      lamp_cooling          = COOLING_RESET;
      lamp_hue_range        = HUE_RANGE_RESET;
      lamp_base_hue         = BASE_HUE_RESET;
      lamp_rotation         = ROTATION_RESET;
      lamp_origin           = ORIGIN_CORNER_RESET;
      lamp_serpentine       = SERPENTINE_RESET;
      lamp_chain_axis       = CHAIN_AXIS_RESET;

      reset = 1'b1;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // edge-case table under the reset settings
      for (int i = 0; i < DIRECTED_COUNT; i++) begin
         want = directed_rows[i].typed ? directed_rows[i].want : shade_pixel(directed_rows[i].px);
         send_pixel(directed_rows[i].px, want);
      end
      pixel_req.valid <= 1'b0;
      drain_results();

      // random pixels; each phase a new lamp setting, geometry swept by phase number
      for (int p = 0; p < PHASE_COUNT; p++) begin
         geo = 4'(p);
         if (p == 0) begin
            cool_set = 8'd0; range_set = 8'd0; hue_set = 8'd0;
         end else if (p == PHASE_COUNT - 1) begin
            cool_set = 8'd255; range_set = 8'd255; hue_set = 8'd255;
         end else begin
            cool_set  = pix_type'($urandom);
            range_set = ($urandom_range(0, 3) == 0) ? pix_type'($urandom)
                                                    : pix_type'($urandom_range(0, 128));
            hue_set   = pix_type'($urandom);
         end
         write_register(CSR_COOLING, cool_set);
         write_register(CSR_HUE_RANGE, range_set);
         write_register(CSR_BASE_HUE, hue_set);
         // junk in the upper bits of the narrow registers must be dropped
         noise = pix_type'($urandom);
         write_register(CSR_ROTATION, {noise[7:2], geo[1:0]});
         noise = pix_type'($urandom);
         write_register(CSR_ORIGIN_CORNER, {noise[7:2], geo[3:2]});
         noise = pix_type'($urandom);
         write_register(CSR_SERPENTINE, {noise[7:1], geo[0] ^ geo[2]});
         noise = pix_type'($urandom);
         write_register(CSR_CHAIN_AXIS, {noise[7:1], geo[1] ^ geo[3]});
         if (p == 2) write_register(CSR_INDEX_UNUSED, pix_type'($urandom));
         @(negedge clock);
         csr_write_en <= 1'b0;

         if (p == 6) begin
            req_idle_pct = 58;
            rsp_idle_pct = 19;
         end
         if (p == 11) begin
            req_idle_pct = 0;
            rsp_idle_pct = 0;
         end
         // long receiver hold while requests keep coming: pipeline fills and stalls
         if (p == 3) hold_off_request = 1'b1;

         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            if (p == 8 && n == ITEMS_PER_PHASE / 2) begin
               pixel_req.valid <= 1'b0;
               drain_results();
            end
            px.face_number = face_type'($urandom);
            px.column      = coord_type'($urandom);
            px.heat_row    = coord_type'($urandom);
            px.heat_here   = ($urandom_range(0, 7) == 0) ? 8'd255 : pix_type'($urandom);
            px.heat_below  = pix_type'($urandom);
            px.phase       = pix_type'($urandom);
            // mostly light cooling so that the brightness is not always clamped to zero
            px.value_mask  = ($urandom_range(0, 3) == 0) ? pix_type'($urandom)
                                                         : pix_type'($urandom_range(0, 31));
            px.tint_mask   = pix_type'($urandom);
            send_pixel(px, shade_pixel(px));
         end
         pixel_req.valid <= 1'b0;
         drain_results();
      end

      // catch any stray results
      repeat (DRAIN_CYCLES) @(negedge clock);
      $display("Shaded %0d of %0d pixel requests over %0d lamp settings, reset defaults first.",
               results_seen, requests_sent, PHASE_COUNT + 1);
      $display("Rotations, origin corners, chain axes and serpentine all swept; %0d mismatches.",
               mismatch_count);
      if (mismatch_count == 0 && pending_pixels.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

// ----- files.f -----
+incdir+hdl
hdl/fps_pkg.sv
hdl/fps_if.sv
hdl/fire_pixel_shader.sv
hdl/fps_checker.sv
tb/tb_fire_pixel_shader.sv
